// ===== rtl/sha_pkg.sv =====
// Shared types and constants for the slot handle allocator.
// No dependencies; the interfaces, top and free ring use scoped names, the dv files import it.
package sha_pkg;

  // Table size; must be a power of two so slot numbers wrap naturally.
  localparam int SLOTS     = 64;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(SLOTS);

  // Fixed widths of the channel fields.
  localparam int OP_W      = 2;
  localparam int IN_IDX_W  = 6;
  localparam int IN_DATA_W = 32;
  localparam int ST_W      = 2;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [DATA_BITS-1:0] data_t;
  typedef logic [OP_W-1:0]      op_t;
  typedef logic [IN_IDX_W-1:0]  in_idx_t;
  typedef logic [IN_DATA_W-1:0] in_data_t;
  typedef logic [ST_W-1:0]      st_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  // Update request for the free slot ring, issued once per executed transaction.
  typedef struct packed {
    logic pop;        // a slot was granted, advance the allocate pointer
    logic push;       // a slot was released, append it at the free pointer
    idx_t push_slot;  // slot number being released
  } ring_cmd_t;

endpackage

// ===== rtl/sha_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on sha_pkg for the field types.
interface sha_req_if;
  logic                 valid;
  logic                 ready;
  sha_pkg::op_t         op;
  sha_pkg::in_idx_t     index_in;
  sha_pkg::in_data_t    data_in;

  modport source (output valid, output op, output index_in, output data_in, input ready);
  modport sink   (input valid, input op, input index_in, input data_in, output ready);
endinterface

interface sha_rsp_if;
  logic                 valid;
  logic                 ready;
  sha_pkg::st_t         status;
  sha_pkg::in_idx_t     slot_out;
  sha_pkg::in_data_t    data_out;
  logic                 data_valid;

  modport source (output valid, output status, output slot_out, output data_out,
                  output data_valid, input ready);
  modport sink   (input valid, input status, input slot_out, input data_out,
                  input data_valid, output ready);
endinterface

// ===== rtl/slot_handle_allocator_top.sv =====
// Top level of the slot handle allocator: input stage, execute logic, result stage.
// Depends on sha_pkg, sha_if, sha_ram and sha_free_ring.
//
//   Channel  Dir  Port    Payload
//   request  in   req_i   op, index_in, data_in
//   response out  rsp_o   status, slot_out, data_out, data_valid
//
// One transaction is accepted per cycle when the result stage can move. A request
// accepted into the input register is executed from it, and its response is registered
// in the result stage once that stage can move. The rate is set by the slot data RAM,
// whose registered read is started as the request is accepted, and by the free ring
// head, which is read ahead from the updated allocate pointer.
// Reset clears the slot-in-use flags, both ring pointers and all valid bits; no
// clearing pass is needed. A stalled response holds the input stage and, through it,
// the request ready.
module slot_handle_allocator_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha_req_if.sink       req_i,
  sha_rsp_if.source     rsp_o
);

  // Input stage
  logic                 s1_vld_q, s1_vld_d;
  sha_pkg::op_t         s1_op_q;
  sha_pkg::idx_t        s1_idx_q;
  sha_pkg::data_t       s1_data_q;
  logic                 s1_fire;
  logic                 req_acc;

  // Slot state
  logic [sha_pkg::SLOTS-1:0] used_q, used_d;
  sha_pkg::idx_t        req_idx;
  sha_pkg::data_t       ram_rdata;
  logic                 dbyp_q;
  sha_pkg::data_t       dbyp_data_q;
  sha_pkg::data_t       slot_rd;
  logic                 data_we;

  // Free ring
  sha_pkg::ring_cmd_t   ring_cmd;
  sha_pkg::idx_t        ring_head;

  // Execute results
  logic                 ins_ok, rem_ok;
  sha_pkg::status_e     status_d;
  sha_pkg::idx_t        slot_d;
  sha_pkg::data_t       dout_d;
  logic                 dval_d;

  // Result stage
  logic                 out_vld_q, out_vld_d;
  sha_pkg::st_t         out_status_q;
  sha_pkg::in_idx_t     out_slot_q;
  sha_pkg::in_data_t    out_data_q;
  logic                 out_dval_q;

  assign s1_fire     = s1_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !s1_vld_q || s1_fire;
  assign req_acc     = req_i.valid && req_i.ready;

  // The index is taken modulo the table size, which is just its low address bits.
  assign req_idx = sha_pkg::idx_t'(req_i.index_in);

  // The stored word is read as the request enters; a write by the transaction
  // leaving the input stage in the same cycle is forwarded.
  assign slot_rd = dbyp_q ? dbyp_data_q : ram_rdata;

  always_comb begin
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    status_d = sha_pkg::ST_OK;
    slot_d   = '0;
    dout_d   = '0;
    dval_d   = 1'b0;
    case (sha_pkg::op_e'(s1_op_q))
      sha_pkg::OP_INSERT: begin
        if (used_q[ring_head]) begin
          status_d = sha_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
          slot_d = ring_head;
        end
      end
      sha_pkg::OP_REMOVE: begin
        if (!used_q[s1_idx_q]) begin
          status_d = sha_pkg::ST_NOT_USED;
        end else begin
          rem_ok = 1'b1;
        end
      end
      sha_pkg::OP_GET: begin
        if (used_q[s1_idx_q]) begin
          dout_d = slot_rd;
          dval_d = 1'b1;
        end
      end
      default: begin
        // Unused operation code: nothing changes, the response is all zero.
      end
    endcase
  end

  always_comb begin
    used_d = used_q;
    if (s1_fire && ins_ok) begin
      used_d[ring_head] = 1'b1;
    end
    if (s1_fire && rem_ok) begin
      used_d[s1_idx_q] = 1'b0;
    end
  end

  assign data_we            = s1_fire && ins_ok;
  assign ring_cmd.pop       = s1_fire && ins_ok;
  assign ring_cmd.push      = s1_fire && rem_ok;
  assign ring_cmd.push_slot = s1_idx_q;

  sha_free_ring u_free_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ring_cmd),
    .head_o (ring_head)
  );

  // Words of removed slots are never cleared here: a read is gated by the in-use flag.
  sha_ram #(
    .WIDTH (sha_pkg::DATA_BITS),
    .DEPTH (sha_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (ring_head),
    .wdata_i (s1_data_q),
    .re_i    (req_acc),
    .raddr_i (req_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (req_acc) begin
      s1_vld_d = 1'b1;
    end else if (s1_fire) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_fire) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      used_q    <= '0;
      dbyp_q    <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
      used_q    <= used_d;
      if (req_acc) begin
        dbyp_q <= data_we && (ring_head == req_idx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_op_q     <= req_i.op;
      s1_idx_q    <= req_idx;
      s1_data_q   <= sha_pkg::data_t'(req_i.data_in);
      dbyp_data_q <= s1_data_q;
    end
    if (s1_fire) begin
      out_status_q <= sha_pkg::st_t'(status_d);
      out_slot_q   <= sha_pkg::in_idx_t'(slot_d);
      out_data_q   <= sha_pkg::in_data_t'(dout_d);
      out_dval_q   <= dval_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_out   = out_slot_q;
  assign rsp_o.data_out   = out_data_q;
  assign rsp_o.data_valid = out_dval_q;

  a_grant_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && ins_ok |=> used_q[$past(ring_head)])
    else $error("granted slot not marked in use");

  a_release_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && rem_ok |=> !used_q[$past(s1_idx_q)])
    else $error("released slot still marked in use");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s1_fire |=> s1_vld_q && $stable(s1_op_q) && $stable(s1_idx_q))
    else $error("input stage changed while stalled");

  a_dval_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_dval_q |-> out_status_q == sha_pkg::ST_OK && out_slot_q == '0)
    else $error("data valid response with nonzero status or slot");

endmodule

// ===== rtl/sha_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// A read at the written address returns the old contents. No dependencies.
module sha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sha_free_ring.sv =====
// Ring of free slot numbers with allocate and free pointers.
// Depends on sha_pkg and sha_ram; presents the slot at the allocate pointer every cycle.
module sha_free_ring (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::ring_cmd_t cmd_i,
  output sha_pkg::idx_t      head_o
);

  sha_pkg::idx_t alloc_ptr_q, alloc_ptr_d;
  sha_pkg::idx_t free_ptr_q,  free_ptr_d;

  // One flag per entry: an entry never written still holds its own index.
  logic [sha_pkg::SLOTS-1:0] ent_vld_q, ent_vld_d;

  sha_pkg::idx_t ram_rdata;
  sha_pkg::idx_t rd_addr_q;
  logic          rd_vld_q;
  logic          byp_q, byp_d;
  sha_pkg::idx_t byp_slot_q;

  always_comb begin
    alloc_ptr_d = alloc_ptr_q;
    free_ptr_d  = free_ptr_q;
    ent_vld_d   = ent_vld_q;
    if (cmd_i.pop) begin
      alloc_ptr_d = alloc_ptr_q + sha_pkg::idx_t'(1);
    end
    if (cmd_i.push) begin
      free_ptr_d            = free_ptr_q + sha_pkg::idx_t'(1);
      ent_vld_d[free_ptr_q] = 1'b1;
    end
    // The RAM returns old data on a collision, so a same-cycle write is forwarded.
    byp_d = cmd_i.push && (free_ptr_q == alloc_ptr_d);
  end

  sha_ram #(
    .WIDTH (sha_pkg::IDX_W),
    .DEPTH (sha_pkg::SLOTS)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (free_ptr_q),
    .wdata_i (cmd_i.push_slot),
    .re_i    (1'b1),
    .raddr_i (alloc_ptr_d),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_ptr_q <= '0;
      free_ptr_q  <= '0;
      ent_vld_q   <= '0;
      rd_addr_q   <= '0;
      rd_vld_q    <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      alloc_ptr_q <= alloc_ptr_d;
      free_ptr_q  <= free_ptr_d;
      ent_vld_q   <= ent_vld_d;
      rd_addr_q   <= alloc_ptr_d;
      rd_vld_q    <= ent_vld_q[alloc_ptr_d];
      byp_q       <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_slot_q <= cmd_i.push_slot;
  end

  assign head_o = byp_q    ? byp_slot_q :
                  rd_vld_q ? ram_rdata  : rd_addr_q;

  a_head_tracks_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> rd_addr_q == alloc_ptr_q)
    else $error("ring read address lost track of the allocate pointer");

  a_fwd_on_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push && (free_ptr_q == alloc_ptr_d) |=> head_o == $past(cmd_i.push_slot))
    else $error("released slot not forwarded to the ring head");

  a_no_pop_and_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.pop && cmd_i.push))
    else $error("ring asked to grant and release in one cycle");

endmodule

// ===== dv/sha_checker.sv =====
// Scoreboard for the slot handle allocator: watches both channels and predicts each response.
// Depends on sha_pkg for field types and codes, and on sha_if for the channel interfaces.
module sha_checker
  import sha_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha_req_if   req_i,
  sha_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    status_e  status;
    in_idx_t  slot;
    in_data_t data;
    logic     data_valid;
  } alloc_result_t;

  // Shadow copy of the table, the free slot ring and its two pointers.
  logic          in_use      [SLOTS];
  data_t         stored_word [SLOTS];
  idx_t          free_list   [SLOTS];
  idx_t          grant_ptr;
  idx_t          release_ptr;
  alloc_result_t awaited_results [$];
  alloc_result_t want;

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic alloc_result_t execute_request(op_t op, in_idx_t index, in_data_t data);
    alloc_result_t res;
    idx_t          slot;
    idx_t          granted;
    res  = '{status: ST_OK, slot: '0, data: '0, data_valid: 1'b0};
    slot = idx_t'(index);
    case (op)
      OP_INSERT: begin
        granted = free_list[grant_ptr];
        if (in_use[granted]) begin
          res.status = ST_FULL;
        end else begin
          in_use[granted]      = 1'b1;
          stored_word[granted] = data_t'(data);
          res.slot             = in_idx_t'(granted);
          grant_ptr            = grant_ptr + idx_t'(1);
        end
      end
      OP_REMOVE: begin
        if (!in_use[slot]) begin
          res.status = ST_NOT_USED;
        end else begin
          in_use[slot]           = 1'b0;
          stored_word[slot]      = '0;
          free_list[release_ptr] = slot;
          release_ptr            = release_ptr + idx_t'(1);
        end
      end
      OP_GET: begin
        if (in_use[slot]) begin
          res.data       = in_data_t'(stored_word[slot]);
          res.data_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i]      = 1'b0;
        stored_word[i] = '0;
        free_list[i]   = idx_t'(i);
      end
      grant_ptr    = '0;
      release_ptr  = '0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        awaited_results.push_back(execute_request(req_i.op, req_i.index_in, req_i.data_in));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("unexpected response: status %0d slot %0d data %h valid %b",
                     rsp_i.status, rsp_i.slot_out, rsp_i.data_out, rsp_i.data_valid);
          end
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp_i.status !== st_t'(want.status) || rsp_i.slot_out !== want.slot ||
              rsp_i.data_out !== want.data || rsp_i.data_valid !== want.data_valid) begin
            if (fail_count_o < 10) begin
              $display("mismatch: expected status %0d slot %0d data %h valid %b",
                       want.status, want.slot, want.data, want.data_valid);
              $display("          got      status %0d slot %0d data %h valid %b",
                       rsp_i.status, rsp_i.slot_out, rsp_i.data_out, rsp_i.data_valid);
            end
            fail_count_o++;
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the slot handle allocator testbench: clock, reset, request and response traffic.
// Depends on sha_pkg, sha_if, slot_handle_allocator_top and the sha_checker scoreboard.
module testbench;
  import sha_pkg::*;

  // The fourth op code has no meaning; the block must answer it with an all-zero response.
  localparam op_t OP_UNUSED   = 2'd3;
  localparam int  RANDOM_ITEMS = 2000;
  localparam int  RUN_LIMIT    = 2_000_000;

  // Flavors of random traffic. Filling pushes the table into the full state, draining
  // empties it again through removes, and the mixed flavor keeps it somewhere in between.
  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int fail_count;
  int pending;
  int burst_left;
  int inserts_sent;

  sha_req_if req_if ();
  sha_rsp_if rsp_if ();

  slot_handle_allocator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  sha_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop in case a transaction never completes.
  initial begin
    #RUN_LIMIT;
    $display("CHECKS FAILED");
    $finish;
  end

  // The response side stalls on a 16-bit pattern that is replayed for a randomly drawn span
  // and then drawn again. A quarter of the patterns are all ones, which gives stretches with
  // no back-pressure at all. Every pattern keeps bit zero high, so no stall lasts past
  // one pass through the pattern.
  initial begin : rsp_stall_gen
    logic [15:0] stall_pattern;
    int          phase_left;
    int          bit_pos;
    stall_pattern = 16'hffff;
    phase_left    = 0;
    bit_pos       = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          stall_pattern = 16'hffff;
        end else begin
          stall_pattern = 16'($urandom) | 16'h0001;
        end
        phase_left = $urandom_range(16, 128);
      end
      rsp_if.ready <= stall_pattern[bit_pos];
      bit_pos = (bit_pos + 1) % 16;
      phase_left--;
    end
  end

  // Sends one request transaction. The request side works in bursts: valid stays high
  // across back-to-back transactions, and between bursts it drops low for a random gap.
  // Fields change only at the falling edge, and acceptance is judged at the rising edge.
  task automatic issue(input op_t op, input in_idx_t index, input in_data_t data);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.index_in <= index;
    req_if.data_in  <= data;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (op == OP_INSERT) begin
      inserts_sent++;
    end
  endtask

  // Holds the request side quiet until every transaction sent so far has been answered.
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Data words lean toward the two extremes now and then.
  function automatic in_data_t pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return in_data_t'($urandom);
    endcase
  endfunction

  // Until the first SLOTS inserts have gone out, the slots from inserts_sent upward have
  // never held data, and reading them is kept out of the stimulus. Every insert succeeds
  // in that period, because the ring still hands out fresh slots in ascending order.
  function automatic in_idx_t pick_get_index();
    if (inserts_sent < SLOTS) begin
      return in_idx_t'($urandom_range(0, inserts_sent - 1));
    end
    return in_idx_t'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic random_phase(input phase_e mode, input int count);
    int      roll;
    int      ins_pct;
    int      rem_pct;
    op_t     op;
    in_idx_t index;
    case (mode)
      PH_FILL: begin
        ins_pct = 70;
        rem_pct = 12;
      end
      PH_DRAIN: begin
        ins_pct = 12;
        rem_pct = 63;
      end
      default: begin
        ins_pct = 35;
        rem_pct = 35;
      end
    endcase
    for (int n = 0; n < count; n++) begin
      // Gets take the rest up to 97 percent; the unused op code gets the last three.
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        op = OP_INSERT;
      end else if (roll < ins_pct + rem_pct) begin
        op = OP_REMOVE;
      end else if (roll < 97) begin
        op = OP_GET;
      end else begin
        op = OP_UNUSED;
      end
      if (op == OP_GET) begin
        index = pick_get_index();
      end else begin
        index = in_idx_t'($urandom_range(0, SLOTS - 1));
      end
      issue(op, index, pick_word());
    end
  endtask

  initial begin : stimulus
    int     random_sent;
    int     phase_len;
    int     phase_no;
    phase_e mode;
    burst_left   = 0;
    inserts_sent = 0;
    random_sent  = 0;
    phase_no     = 0;
    req_if.valid    <= 1'b0;
    req_if.op       <= OP_INSERT;
    req_if.index_in <= '0;
    req_if.data_in  <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening. The first four inserts take slots zero to three and store both
    // data extremes; the index given with an insert must be ignored.
    issue(OP_INSERT, '0, '0);
    issue(OP_INSERT, '1, '1);
    issue(OP_INSERT, '1, 32'ha5a5_a5a5);
    issue(OP_INSERT, 6'd17, 32'h5a5a_5a5a);
    issue(OP_GET, 6'd0, '1);
    issue(OP_GET, 6'd1, '0);
    issue(OP_GET, 6'd3, '0);
    // The unused op code with every other field at its top value.
    issue(OP_UNUSED, '1, '1);
    // Removing a used slot, removing it a second time, then reading the freed slot,
    // whose data must not come back.
    issue(OP_REMOVE, 6'd1, '1);
    issue(OP_REMOVE, 6'd1, '0);
    issue(OP_GET, 6'd1, '0);
    // The highest index has never been granted, so this remove must be refused.
    issue(OP_REMOVE, '1, '0);
    issue(OP_INSERT, 6'd0, 32'h1234_5678);
    issue(OP_GET, 6'd4, '0);
    issue(OP_REMOVE, 6'd0, '0);
    issue(OP_REMOVE, 6'd2, '0);
    issue(OP_REMOVE, 6'd3, '0);
    issue(OP_REMOVE, 6'd4, '0);
    issue(OP_GET, 6'd2, '1);
    issue(OP_UNUSED, '0, '0);
    settle();

    // Random part: fill, drain and mixed phases take turns. Filling runs the table into
    // the full state, after which the ring hands out recycled slot numbers; draining
    // brings the table back down, and the mixed phase keeps it somewhere in between.
    while (random_sent < RANDOM_ITEMS) begin
      mode      = phase_e'(phase_no % 3);
      phase_len = $urandom_range(120, 220);
      random_phase(mode, phase_len);
      random_sent += phase_len;
      phase_no++;
      if ($urandom_range(0, 1) == 0) begin
        settle();
      end
    end

    // Let every response drain, then idle with the request side quiet, so that any stray
    // response would still be caught before the run ends.
    settle();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_ram.sv
rtl/sha_free_ring.sv
rtl/slot_handle_allocator_top.sv
dv/sha_checker.sv
dv/testbench.sv
